// ===== rtl/dsp_pkg.sv =====
// shared constants, types and calendar functions for the span progress block
package dsp_pkg;

    localparam int unsigned QuoW   = 20;
    localparam int unsigned SpanW  = 32;
    localparam int unsigned MinW   = 34;
    localparam logic [QuoW-1:0] FullScale = 20'd1000000;
    localparam logic [31:0] StartReset = 32'd2123433984;
    localparam logic [31:0] EndReset   = 32'd2124217851;
    localparam logic [0:0] RegStart = 1'b0;
    localparam logic [0:0] RegEnd   = 1'b1;

    // shared pipeline control between the front end and the divider row
    typedef struct packed {
        logic            valid;
        logic            zero;
        logic            full;
    } t_ctl;

    // one partial division step, carried down the cell row
    typedef struct packed {
        t_ctl               ctl;
        logic [SpanW:0]     rem;
        logic [SpanW-1:0]   den;
        logic [QuoW+SpanW-1:0] num;
        logic [QuoW-1:0]    quo;
    } t_div;

    // julian day number of a date; year 0..4095, month 0..15, day 0..31
    function automatic logic [21:0] day_number(input logic [11:0] y,
                                               input logic [3:0] m,
                                               input logic [4:0] d);
        logic        jan_feb;
        logic [13:0] ya;
        logic [23:0] t1;
        logic [12:0] t2;
        logic [6:0]  cen;
        logic [8:0]  t3;
        logic [4:0]  mm;
        logic [24:0] p2;
        logic [26:0] p3;
        begin
            // m-14 ranges -14..1; /12 toward zero gives -1 for -14..-12 (m 0..2), else 0
            jan_feb = (m <= 4'd2);
            ya  = {2'b0, y} + (jan_feb ? 14'd4799 : 14'd4800);
            t1  = (24'(ya) * 24'd1461) >> 2;
            mm  = jan_feb ? (5'(m) + 5'd10) : (5'(m) - 5'd2);
            // 367*mm/12 as a reciprocal multiply, exact for mm up to 13
            p2  = 25'(mm) * 25'd1002277;
            t2  = 13'(p2 >> 15);
            // (ya+100)/100 as a reciprocal multiply, exact below 9000
            p3  = 27'(ya + 14'd100) * 27'd5243;
            cen = 7'(p3 >> 19);
            t3  = 9'((11'(cen) * 11'd3) >> 2);
            day_number = 22'(t1 + 24'(t2) - 24'(t3) + 24'(d) - 24'd32075);
        end
    endfunction

    function automatic logic [MinW-1:0] to_minutes(input logic [21:0] jdn,
                                                   input logic [4:0] h,
                                                   input logic [5:0] mi);
        to_minutes = MinW'(jdn) * MinW'(1440) + MinW'(h) * MinW'(60) + MinW'(mi);
    endfunction

endpackage

// ===== rtl/dsp_if.sv =====
// valid/ready channel interfaces
interface dsp_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    modport source (output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
                    input ready);
    modport sink (input valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
                  output ready);
endinterface

interface dsp_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] progress_millionths;
    logic        done_res;
    modport source (output valid, progress_millionths, done_res, input ready);
    modport sink (input valid, progress_millionths, done_res, output ready);
endinterface

interface dsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/dsp_cell.sv =====
// one restoring division cell: takes one numerator bit per cycle while i_en is high
module dsp_cell
    import dsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_div  i_d,
    output t_div  o_d
);
    t_div r_d;
    t_div n_d;
    logic [SpanW:0] shifted;

    always_comb begin
        n_d = i_d;
        shifted = {i_d.rem[SpanW-1:0], i_d.num[QuoW+SpanW-1]};
        n_d.num = {i_d.num[QuoW+SpanW-2:0], 1'b0};
        if (shifted >= {1'b0, i_d.den}) begin
            n_d.rem = shifted - {1'b0, i_d.den};
            n_d.quo = {i_d.quo[QuoW-2:0], 1'b1};
        end else begin
            n_d.rem = shifted;
            n_d.quo = {i_d.quo[QuoW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.ctl <= '0;
        end else if (i_en) begin
            r_d.ctl <= n_d.ctl;
        end
        if (i_en) begin
            r_d.rem <= n_d.rem;
            r_d.den <= n_d.den;
            r_d.num <= n_d.num;
            r_d.quo <= n_d.quo;
        end
    end

    assign o_d = r_d;
endmodule

// ===== rtl/datetime_span_progress.sv =====
// top level: span progress with a row of division cells
//
//  channel | dir | payload
//  in      | in  | cur_year, cur_month, cur_day, cur_hour, cur_minute
//  cfg     | in  | index (0 start, 1 end), data (packed stamp)
//  out     | out | progress_millionths, done_res
//
// one item per cycle while the output register is empty or being taken; an item
// passes 3 front-end stages, then 20 division cells, then the output register
// the whole row advances together; it stalls whenever the output register
// holds an untaken result
// reset restores the start and end stamps and empties the row
// cfg is always ready
module datetime_span_progress
    import dsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dsp_in_if.sink    in_ch,
    dsp_cfg_if.sink   cfg_ch,
    dsp_out_if.source out_ch
);
    logic [31:0] r_start;
    logic [31:0] r_end;

    // stage 0: day numbers, hour and minute kept alongside
    logic [21:0] r_jc, r_js, r_je;
    logic [10:0] r_tc, r_ts, r_te;
    logic        r_v0;
    // stage 1: minute counts
    logic [MinW-1:0] r_cur, r_st, r_en;
    logic            r_v1;
    // stage 2: compare, elapsed, span
    t_div r_s2;
    t_div chain [QuoW+1];
    logic en;
    logic r_ov;
    logic [QuoW-1:0] r_oq;
    logic r_od;
    logic [MinW-1:0] elapsed, span;
    logic [QuoW+SpanW-1:0] scaled;

    assign cfg_ch.ready = 1'b1;
    // advance when the output slot is empty or being taken
    assign en = !r_ov || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= StartReset;
            r_end   <= EndReset;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                RegStart: r_start <= cfg_ch.data;
                RegEnd:   r_end   <= cfg_ch.data;
                default:  ;
            endcase
        end
    end

    // day numbers of the current moment and both stamps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= in_ch.valid;
        end
        if (en) begin
            r_jc <= day_number(in_ch.cur_year, in_ch.cur_month, in_ch.cur_day);
            r_js <= day_number(r_start[31:20], r_start[19:16], r_start[15:11]);
            r_je <= day_number(r_end[31:20], r_end[19:16], r_end[15:11]);
            r_tc <= {in_ch.cur_hour, in_ch.cur_minute};
            r_ts <= r_start[10:0];
            r_te <= r_end[10:0];
        end
    end

    // minute counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
        if (en) begin
            r_cur <= to_minutes(r_jc, r_tc[10:6], r_tc[5:0]);
            r_st  <= to_minutes(r_js, r_ts[10:6], r_ts[5:0]);
            r_en  <= to_minutes(r_je, r_te[10:6], r_te[5:0]);
        end
    end

    assign elapsed = r_cur - r_st;
    assign span    = r_en - r_st;
    assign scaled  = (QuoW+SpanW)'(elapsed[SpanW-1:0]) * (QuoW+SpanW)'(FullScale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.ctl <= '0;
        end else if (en) begin
            r_s2.ctl.valid <= r_v1;
            r_s2.ctl.zero  <= (r_cur <= r_st);
            r_s2.ctl.full  <= (r_cur > r_st) && (r_cur >= r_en);
        end
        if (en) begin
            // inside the open span both fit in 32 bits; the top bits of the
            // scaled numerator are already below the span, so they seed the
            // remainder and the row only works through the low 20 bits
            r_s2.rem <= (SpanW+1)'(scaled[QuoW+SpanW-1:QuoW]);
            r_s2.den <= span[SpanW-1:0];
            r_s2.num <= {scaled[QuoW-1:0], {SpanW{1'b0}}};
            r_s2.quo <= '0;
        end
    end

    assign chain[0] = r_s2;
    for (genvar g = 0; g < QuoW; g++) begin : g_cell
        dsp_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_d    (chain[g]),
            .o_d    (chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= chain[QuoW].ctl.valid;
        end
        if (en) begin
            r_oq <= chain[QuoW].ctl.zero ? '0 :
                    chain[QuoW].ctl.full ? FullScale : chain[QuoW].quo;
            r_od <= !chain[QuoW].ctl.zero && chain[QuoW].ctl.full;
        end
    end

    assign out_ch.valid = r_ov;
    assign out_ch.progress_millionths = r_oq;
    assign out_ch.done_res = r_od;

    a_done_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_od == (r_oq == FullScale))) else $error("done flag mismatch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> r_ov) else $error("result dropped");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_oq <= FullScale)) else $error("progress out of range");
endmodule

// ===== bench/datetime_span_progress_tb.sv =====
// testbench for the span progress block: random and directed moments checked against a predictor
`timescale 1ns / 1ps

module datetime_span_progress_tb
    import dsp_pkg::*;
();

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_moment;

    typedef struct packed {
        logic [19:0] progress;
        logic        done;
    } t_progress;

    logic i_clk;
    logic i_rst_n;

    dsp_in_if  in_ch  ();
    dsp_cfg_if cfg_ch ();
    dsp_out_if out_ch ();

    datetime_span_progress u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .cfg_ch  (cfg_ch),
        .out_ch  (out_ch)
    );

    // moments waiting to be sent, and progress values waiting to come back
    t_moment   pending_moments[$];
    t_progress expected_progress[$];

    // predictor's copy of the two stamp registers
    logic [31:0] model_start;
    logic [31:0] model_end;

    // when set, neither side inserts idle cycles
    logic quiet;
    int   send_gap;
    int   recv_stall;
    int   errors = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // minutes since the day-number epoch, with out-of-range fields used as given
    function automatic longint moment_minutes(t_moment mo);
        longint y, m, d, h, mi, a, jdn;
        y  = mo.year;
        m  = mo.month;
        d  = mo.day;
        h  = mo.hour;
        mi = mo.minute;
        // signed division truncates toward zero, so months 0..2 give -1
        a   = (m - 14) / 12;
        jdn = (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
            - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075;
        return jdn * 1440 + h * 60 + mi;
    endfunction

    function automatic t_moment unpack_stamp(logic [31:0] s);
        return t_moment'(s);
    endfunction

    function automatic t_progress span_progress(t_moment cur_m);
        longint    cur, st, en;
        longint    prog;
        t_progress r;
        cur = moment_minutes(cur_m);
        st  = moment_minutes(unpack_stamp(model_start));
        en  = moment_minutes(unpack_stamp(model_end));
        // at or before start wins over an empty or reversed span
        if (cur <= st) prog = 0;
        else if (cur >= en) prog = 1000000;
        else prog = ((cur - st) * 1000000) / (en - st);
        r.progress = prog[19:0];
        r.done     = (prog >= 1000000);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // sender: holds an offered moment until taken, idles in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.cur_year   <= '0;
            in_ch.cur_month  <= '0;
            in_ch.cur_day    <= '0;
            in_ch.cur_hour   <= '0;
            in_ch.cur_minute <= '0;
            send_gap         <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // offer stays put until the transfer happens
        end else begin
            if (in_ch.valid) void'(pending_moments.pop_front());
            if (send_gap > 0) begin
                send_gap    <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                send_gap    <= $urandom_range(0, 18);
                in_ch.valid <= 1'b0;
            end else if (pending_moments.size() > 0) begin
                // front was just popped above if a transfer happened
                in_ch.valid <= 1'b1;
                {in_ch.cur_year, in_ch.cur_month, in_ch.cur_day, in_ch.cur_hour,
                 in_ch.cur_minute} <= pending_moments[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: ready drops in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall   <= 0;
        end else if (recv_stall > 0) begin
            recv_stall   <= recv_stall - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            recv_stall   <= $urandom_range(0, 18);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // predictor and checker, all on transfers seen at the clock edge
    always @(posedge i_clk) begin
        t_progress want;
        if (!i_rst_n) begin
            model_start <= StartReset;
            model_end   <= EndReset;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == RegStart) model_start <= cfg_ch.data;
                else model_end <= cfg_ch.data;
            end
            if (in_ch.valid && in_ch.ready)
                expected_progress.push_back(span_progress({in_ch.cur_year,
                    in_ch.cur_month, in_ch.cur_day, in_ch.cur_hour, in_ch.cur_minute}));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_progress.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = expected_progress.pop_front();
                    if (out_ch.progress_millionths !== want.progress)
                        report_mismatch($sformatf("progress got %0d want %0d",
                            out_ch.progress_millionths, want.progress));
                    if (out_ch.done_res !== want.done)
                        report_mismatch($sformatf("done got %0b want %0b",
                            out_ch.done_res, want.done));
                end
            end
        end
    end

    task automatic write_stamp(logic [0:0] idx, logic [31:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // all queued moments sent and answered, then let the row empty out
    task automatic drain();
        @(negedge i_clk);
        while (pending_moments.size() > 0 || in_ch.valid || expected_progress.size() > 0)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // mix of wild fields, moments near either stamp and moments in between
    function automatic t_moment pick_moment(logic [31:0] st, logic [31:0] en);
        t_moment m, a, b;
        int      sel;
        a   = unpack_stamp(st);
        b   = unpack_stamp(en);
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            m = t_moment'($urandom);
        end else if (sel < 6) begin
            m = (sel < 4) ? a : b;
            m.minute = 6'($urandom_range(0, 63));
            if (sel[0]) m.hour = 5'($urandom_range(0, 23));
        end else begin
            m.year   = (a.year < b.year) ? 12'($urandom_range(a.year, b.year))
                                         : 12'($urandom_range(b.year, a.year));
            m.month  = 4'($urandom_range(1, 12));
            m.day    = 5'($urandom_range(1, 28));
            m.hour   = 5'($urandom_range(0, 23));
            m.minute = 6'($urandom_range(0, 59));
        end
        return m;
    endfunction

    task automatic run_setting(logic [31:0] st, logic [31:0] en, int n);
        write_stamp(RegStart, st);
        write_stamp(RegEnd, en);
        repeat (n) pending_moments.push_back(pick_moment(st, en));
        drain();
    endtask

    function automatic logic [31:0] random_stamp();
        return {12'($urandom_range(2000, 2050)), 4'($urandom_range(1, 12)),
                5'($urandom_range(1, 28)), 5'($urandom_range(0, 23)),
                6'($urandom_range(0, 59))};
    endfunction

    initial begin
        logic [31:0] s, e;
        i_rst_n          = 1'b0;
        quiet            = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = RegStart;
        cfg_ch.data      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed moments against the reset stamps (all of 2025)
        pending_moments.push_back(unpack_stamp(StartReset));            // exactly start
        pending_moments.push_back(unpack_stamp(EndReset));              // exactly end
        pending_moments.push_back(unpack_stamp(StartReset + 32'd1));    // just after start
        pending_moments.push_back(unpack_stamp(EndReset - 32'd1));      // just before end
        pending_moments.push_back('{12'd2025, 4'd7, 5'd2, 5'd12, 6'd0});
        pending_moments.push_back('{12'd2024, 4'd12, 5'd31, 5'd23, 6'd59});
        pending_moments.push_back('{12'd2026, 4'd1, 5'd1, 5'd0, 6'd0});
        pending_moments.push_back('0);                                  // all fields zero
        pending_moments.push_back('1);                                  // all fields maxed
        pending_moments.push_back('{12'd2025, 4'd0, 5'd15, 5'd3, 6'd4});  // month zero
        pending_moments.push_back('{12'd2025, 4'd1, 5'd31, 5'd0, 6'd0});
        pending_moments.push_back('{12'd2025, 4'd2, 5'd29, 5'd0, 6'd0});
        pending_moments.push_back('{12'd2025, 4'd3, 5'd0, 5'd0, 6'd0});   // day zero
        pending_moments.push_back('{12'd2025, 4'd13, 5'd1, 5'd0, 6'd0});
        pending_moments.push_back('{12'd2025, 4'd14, 5'd1, 5'd0, 6'd0});
        pending_moments.push_back('{12'd2025, 4'd15, 5'd1, 5'd0, 6'd0});
        pending_moments.push_back('{12'd2025, 4'd6, 5'd10, 5'd31, 6'd63}); // hour, minute over
        pending_moments.push_back('{12'd0, 4'd1, 5'd1, 5'd0, 6'd0});
        pending_moments.push_back('{12'd4095, 4'd12, 5'd31, 5'd23, 6'd59});
        drain();

        // random part over several stamp settings
        run_setting(StartReset, EndReset, 100);
        s = random_stamp();
        e = random_stamp();
        run_setting(s, e, 90);
        // short span within one day
        s = random_stamp();
        e = s;
        e[5:0] = 6'd59;
        e[10:6] = 5'($urandom_range(s[10:6], 23));
        run_setting(s, e, 90);
        s = random_stamp();
        run_setting(s, s, 50);                     // empty span
        run_setting(EndReset, StartReset, 50);     // end before start
        run_setting(32'h0000_0000, 32'hFFFF_FFFF, 60);
        run_setting(32'hFFFF_FFFF, 32'h0000_0000, 40);
        run_setting(32'h0000_0000, 32'h0000_0000, 30);

        // closing stretch at full rate
        quiet = 1'b1;
        run_setting(StartReset, EndReset, 140);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule
